/* src/hrs_pkg.sv */
package hrs_pkg;

	localparam int REPORT_KEYS = 6;
	localparam int MAX_BYTES   = 40;
	localparam int CNT_W       = $clog2(MAX_BYTES + 1);
	localparam int KIDX_W      = $clog2(REPORT_KEYS);
	localparam int S_TDATA_W   = 8 + 8 * REPORT_KEYS;

	localparam logic [7:0] EXT_PREFIX    = 8'hE0;
	localparam logic [7:0] BREAK_BIT     = 8'h80;
	localparam logic [7:0] USAGE_ERR_LO  = 8'h01;
	localparam logic [7:0] USAGE_ERR_HI  = 8'h03;
	localparam logic [7:0] USAGE_FIRST   = 8'h04;

	typedef logic [REPORT_KEYS-1:0][7:0] keys_t;

	typedef struct packed {
		logic       ext;
		logic [7:0] sc;
	} code_t;

	typedef struct packed {
		logic clr;
		logic ld;
	} lane_ctrl_t;

	typedef struct packed {
		logic       brk_pend;
		logic       match;
		logic       empty;
		logic [7:0] key;
	} lane_stat_t;

	function automatic code_t mod_code(input logic [2:0] idx);
		code_t c;
		case (idx)
			3'd0: c = '{1'b0, 8'h1D};
			3'd1: c = '{1'b0, 8'h2A};
			3'd2: c = '{1'b0, 8'h38};
			3'd3: c = '{1'b1, 8'h5B};
			3'd4: c = '{1'b1, 8'h1D};
			3'd5: c = '{1'b0, 8'h36};
			3'd6: c = '{1'b1, 8'h38};
			default: c = '{1'b1, 8'h5C};
		endcase
		return c;
	endfunction

	function automatic code_t usage_code(input logic [7:0] u);
		code_t c;
		c = '{1'b0, 8'h00};
		case (u)
			8'h04: c.sc = 8'h1E;  8'h05: c.sc = 8'h30;  8'h06: c.sc = 8'h2E;
			8'h07: c.sc = 8'h20;  8'h08: c.sc = 8'h12;  8'h09: c.sc = 8'h21;
			8'h0A: c.sc = 8'h22;  8'h0B: c.sc = 8'h23;  8'h0C: c.sc = 8'h17;
			8'h0D: c.sc = 8'h24;  8'h0E: c.sc = 8'h25;  8'h0F: c.sc = 8'h26;
			8'h10: c.sc = 8'h32;  8'h11: c.sc = 8'h31;  8'h12: c.sc = 8'h18;
			8'h13: c.sc = 8'h19;  8'h14: c.sc = 8'h10;  8'h15: c.sc = 8'h13;
			8'h16: c.sc = 8'h1F;  8'h17: c.sc = 8'h14;  8'h18: c.sc = 8'h16;
			8'h19: c.sc = 8'h2F;  8'h1A: c.sc = 8'h11;  8'h1B: c.sc = 8'h2D;
			8'h1C: c.sc = 8'h15;  8'h1D: c.sc = 8'h2C;
			8'h1E: c.sc = 8'h02;  8'h1F: c.sc = 8'h03;  8'h20: c.sc = 8'h04;
			8'h21: c.sc = 8'h05;  8'h22: c.sc = 8'h06;  8'h23: c.sc = 8'h07;
			8'h24: c.sc = 8'h08;  8'h25: c.sc = 8'h09;  8'h26: c.sc = 8'h0A;
			8'h27: c.sc = 8'h0B;
			8'h28: c.sc = 8'h1C;  8'h29: c.sc = 8'h01;  8'h2A: c.sc = 8'h0E;
			8'h2B: c.sc = 8'h0F;  8'h2C: c.sc = 8'h39;  8'h2D: c.sc = 8'h0C;
			8'h2E: c.sc = 8'h0D;  8'h2F: c.sc = 8'h1A;  8'h30: c.sc = 8'h1B;
			8'h31: c.sc = 8'h2B;  8'h33: c.sc = 8'h27;  8'h34: c.sc = 8'h28;
			8'h35: c.sc = 8'h29;  8'h36: c.sc = 8'h33;  8'h37: c.sc = 8'h34;
			8'h38: c.sc = 8'h35;  8'h39: c.sc = 8'h3A;
			8'h3A: c.sc = 8'h3B;  8'h3B: c.sc = 8'h3C;  8'h3C: c.sc = 8'h3D;
			8'h3D: c.sc = 8'h3E;  8'h3E: c.sc = 8'h3F;  8'h3F: c.sc = 8'h40;
			8'h40: c.sc = 8'h41;  8'h41: c.sc = 8'h42;  8'h42: c.sc = 8'h43;
			8'h43: c.sc = 8'h44;  8'h44: c.sc = 8'h57;  8'h45: c.sc = 8'h58;
			8'h46: c.sc = 8'h46;  8'h47: c.sc = 8'h46;
			8'h49: c = '{1'b1, 8'h52};  8'h4A: c = '{1'b1, 8'h47};
			8'h4B: c = '{1'b1, 8'h49};  8'h4C: c = '{1'b1, 8'h53};
			8'h4D: c = '{1'b1, 8'h4F};  8'h4E: c = '{1'b1, 8'h51};
			8'h4F: c = '{1'b1, 8'h4D};  8'h50: c = '{1'b1, 8'h4B};
			8'h51: c = '{1'b1, 8'h50};  8'h52: c = '{1'b1, 8'h48};
			8'h54: c = '{1'b1, 8'h35};
			8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'hE4, 8'hE5, 8'hE6, 8'hE7:
				c = mod_code(u[2:0]);
			default: c = '{1'b0, 8'h00};
		endcase
		return c;
	endfunction

endpackage

/* src/hid_report_to_set1_scancodes_top.sv */
// channel  | signals                        | contents
// ---------+--------------------------------+---------------------------------------------
// s (in)   | s_tvalid s_tready s_tdata s_tuser | one report or release-all command
// m (out)  | m_tvalid m_tready m_tdata m_tlast | one set-1 scancode byte, tlast on final
// a report walks the modifier changes, then the slot breaks, then the six report keys;
// a release skips the keys; each 0xE0 prefix is a byte of its own, at most 40 bytes go out
// the event sequencer walks one modifier, slot or report key a cycle, unless a prefix or
// an output stall holds it, while the slot lanes compare in parallel
// one byte is held back so tlast can be known; output stalls freeze the sequencer
// reset clears held modifiers and all key slots
module hid_report_to_set1_scancodes_top
	import hrs_pkg::*;
#(
	parameter int KEY_SLOTS = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // modifiers, key0, key1, key2, key3, key4, key5
	input  logic                 s_tuser,   // cmd
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,   // scan_byte
	output logic                 m_tlast
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MOD  = 3'd1;
	localparam logic [2:0] ST_BRK  = 3'd2;
	localparam logic [2:0] ST_MAKE = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]        state_q;
	logic              rel_q;
	logic [7:0]        tgt_mod_q;
	logic [7:0]        hmod_q;
	keys_t             keys_q;
	logic [KIDX_W-1:0] kidx_q;
	logic              ext_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              pend_v_q;
	logic [7:0]        pend_q;
	logic              m_tvalid_q;
	logic [7:0]        m_tdata_q;
	logic              m_tlast_q;

	keys_t      in_keys;
	logic       rollover;
	logic       accept;
	logic       out_free;
	logic       step_en;
	logic [7:0] diff;
	logic [7:0] mod_oh;
	logic [2:0] mod_idx;
	logic [7:0] cur_key;
	logic       make_ok;
	logic       ev_act;
	code_t      ev_code;
	logic       ev_brk;
	logic       ev_done;
	logic       prefix_now;
	logic       emit_req;
	logic [7:0] emit_byte;
	logic       produce;
	logic       push_mid;
	logic       push_last;

	lane_stat_t           stat [KEY_SLOTS];
	lane_ctrl_t           ctrl [KEY_SLOTS];
	logic                 any_brk;
	logic                 any_match;
	logic [KEY_SLOTS-1:0] brk_oh;
	logic [KEY_SLOTS-1:0] empty_oh;
	logic [7:0]           brk_key;
	logic [KEY_SLOTS-1:0] clr_vec;
	logic [KEY_SLOTS-1:0] ld_vec;

	assign in_keys = keys_t'(s_tdata[S_TDATA_W-1:8]);

	always_comb begin
		rollover = 1'b0;
		for (int j = 0; j < REPORT_KEYS; j++) begin
			if (in_keys[j] inside {[USAGE_ERR_LO:USAGE_ERR_HI]}) begin
				rollover = 1'b1;
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign step_en  = !pend_v_q || out_free;

	assign diff    = hmod_q ^ tgt_mod_q;
	assign mod_oh  = diff & (~diff + 8'd1);
	assign cur_key = keys_q[kidx_q];
	assign make_ok = (cur_key >= USAGE_FIRST) && !any_match;

	always_comb begin
		mod_idx = 3'd0;
		for (int i = 0; i < 8; i++) begin
			if (mod_oh[i]) begin
				mod_idx = mod_idx | 3'(i);
			end
		end
	end

	always_comb begin
		ev_act  = 1'b0;
		ev_code = '{1'b0, 8'h00};
		ev_brk  = 1'b0;
		case (state_q)
			ST_MOD: begin
				ev_act  = |diff;
				ev_code = mod_code(mod_idx);
				ev_brk  = |(hmod_q & mod_oh);
			end
			ST_BRK: begin
				ev_act  = any_brk;
				ev_code = usage_code(brk_key);
				ev_brk  = 1'b1;
			end
			ST_MAKE: begin
				ev_act  = make_ok;
				ev_code = usage_code(cur_key);
			end
			default: begin
				ev_act = 1'b0;
			end
		endcase
	end

	always_comb begin
		ev_done    = 1'b0;
		prefix_now = 1'b0;
		emit_req   = 1'b0;
		emit_byte  = 8'd0;
		if (ev_act) begin
			if (ev_code.sc == 8'd0) begin
				ev_done = 1'b1;
			end else if (ev_code.ext && !ext_q) begin
				prefix_now = 1'b1;
				emit_req   = 1'b1;
				emit_byte  = EXT_PREFIX;
			end else begin
				emit_req  = 1'b1;
				emit_byte = ev_brk ? (ev_code.sc | BREAK_BIT) : ev_code.sc;
				ev_done   = 1'b1;
			end
		end
	end

	assign produce   = step_en && emit_req && (cnt_q < CNT_W'(MAX_BYTES));
	assign push_mid  = produce && pend_v_q;
	assign push_last = (state_q == ST_DONE) && step_en && pend_v_q;

	assign clr_vec = (state_q == ST_BRK && step_en && ev_done) ? brk_oh : '0;
	assign ld_vec  = (state_q == ST_MAKE && step_en && ev_done) ? empty_oh : '0;

	always_comb begin
		for (int i = 0; i < KEY_SLOTS; i++) begin
			ctrl[i].clr = clr_vec[i];
			ctrl[i].ld  = ld_vec[i];
		end
	end

	for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
		hrs_slot_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.keys   (keys_q),
			.cand   (cur_key),
			.rel    (rel_q),
			.ctrl   (ctrl[g]),
			.stat   (stat[g])
		);
	end

	hrs_merge #(
		.KEY_SLOTS (KEY_SLOTS)
	) u_merge (
		.stat      (stat),
		.any_brk   (any_brk),
		.any_match (any_match),
		.brk_oh    (brk_oh),
		.empty_oh  (empty_oh),
		.brk_key   (brk_key)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rel_q     <= 1'b0;
			tgt_mod_q <= 8'd0;
			hmod_q    <= 8'd0;
			keys_q    <= '0;
			kidx_q    <= '0;
			ext_q     <= 1'b0;
			cnt_q     <= '0;
		end else if (accept) begin
			rel_q     <= s_tuser || rollover;
			tgt_mod_q <= (s_tuser || rollover) ? 8'd0 : s_tdata[7:0];
			keys_q    <= in_keys;
			kidx_q    <= '0;
			ext_q     <= 1'b0;
			cnt_q     <= '0;
			state_q   <= ST_MOD;
		end else if (step_en) begin
			ext_q <= prefix_now;
			if (produce) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			case (state_q)
				ST_MOD: begin
					if (!(|diff)) begin
						state_q <= ST_BRK;
					end else if (ev_done) begin
						hmod_q <= hmod_q ^ mod_oh;
					end
				end
				ST_BRK: begin
					if (!any_brk) begin
						state_q <= rel_q ? ST_DONE : ST_MAKE;
					end
				end
				ST_MAKE: begin
					if (!ev_act || ev_done) begin
						if (kidx_q == KIDX_W'(REPORT_KEYS - 1)) begin
							state_q <= ST_DONE;
						end else begin
							kidx_q <= kidx_q + KIDX_W'(1);
						end
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (produce) begin
				pend_v_q <= 1'b1;
			end else if (push_last) begin
				pend_v_q <= 1'b0;
			end
			if (push_mid || push_last) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			pend_q <= emit_byte;
		end
		if (push_mid || push_last) begin
			m_tdata_q <= pend_q;
			m_tlast_q <= push_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

`ifndef SYNTHESIS
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pend_v_q)
		else $error("byte held back while idle");

	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_BYTES))
		else $error("byte count beyond cap");

	a_rel_mods: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BRK && rel_q) |-> hmod_q == 8'd0)
		else $error("modifiers still held after release");

	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(ld_vec))
		else $error("more than one slot loaded");

	a_ext_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ext_q |-> (state_q == ST_MOD || state_q == ST_BRK || state_q == ST_MAKE))
		else $error("prefix pending outside a phase");
`endif

endmodule

/* src/hrs_slot_lane.sv */
module hrs_slot_lane
	import hrs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  keys_t      keys,
	input  logic [7:0] cand,
	input  logic       rel,
	input  lane_ctrl_t ctrl,
	output lane_stat_t stat
);

	logic [7:0] slot_q;
	logic       present;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= 8'd0;
		end else if (ctrl.clr) begin
			slot_q <= 8'd0;
		end else if (ctrl.ld) begin
			slot_q <= cand;
		end
	end

	always_comb begin
		present = 1'b0;
		for (int j = 0; j < REPORT_KEYS; j++) begin
			if (keys[j] == slot_q) begin
				present = 1'b1;
			end
		end
	end

	assign stat.key      = slot_q;
	assign stat.empty    = (slot_q == 8'd0);
	assign stat.match    = !stat.empty && (slot_q == cand);
	assign stat.brk_pend = !stat.empty && (rel || !present);

endmodule

/* src/hrs_merge.sv */
module hrs_merge
	import hrs_pkg::*;
#(
	parameter int KEY_SLOTS = 6
) (
	input  lane_stat_t           stat [KEY_SLOTS],
	output logic                 any_brk,
	output logic                 any_match,
	output logic [KEY_SLOTS-1:0] brk_oh,
	output logic [KEY_SLOTS-1:0] empty_oh,
	output logic [7:0]           brk_key
);

	logic [KEY_SLOTS-1:0] brk_vec;
	logic [KEY_SLOTS-1:0] empty_vec;
	logic [KEY_SLOTS-1:0] match_vec;

	always_comb begin
		for (int i = 0; i < KEY_SLOTS; i++) begin
			brk_vec[i]   = stat[i].brk_pend;
			empty_vec[i] = stat[i].empty;
			match_vec[i] = stat[i].match;
		end
	end

	// lowest set bit wins
	assign brk_oh    = brk_vec & (~brk_vec + KEY_SLOTS'(1));
	assign empty_oh  = empty_vec & (~empty_vec + KEY_SLOTS'(1));
	assign any_brk   = |brk_vec;
	assign any_match = |match_vec;

	always_comb begin
		brk_key = 8'd0;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			if (brk_oh[i]) begin
				brk_key = brk_key | stat[i].key;
			end
		end
	end

endmodule
